/* hw/rtl/ipv4_tcp_checksum_recompute_top_macros.svh */
// Assertion macros shared by the checker of the checksum block.
`ifndef IPV4_TCP_CHECKSUM_RECOMPUTE_TOP_MACROS_SVH
`define IPV4_TCP_CHECKSUM_RECOMPUTE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define ICR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("checksum block check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define ICR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("checksum block check failed");

`endif

/* hw/rtl/icr_pkg.sv */
// Shared types, constants and the ones-complement adder for the checksum block.
package icr_pkg;

	// Protocol number of TCP in the IPv4 header.
	localparam logic [7:0] PROTO_TCP = 8'd6;
	// Byte offset of the IPv4 header checksum field.
	localparam logic [15:0] IP_CKSUM_POS = 16'd10;
	// Byte offset of the TCP checksum field within the segment.
	localparam logic [15:0] TCP_CKSUM_OFS = 16'd16;
	// First and last word offsets of the source and destination addresses.
	localparam logic [15:0] ADDR_FIRST_POS = 16'd12;
	localparam logic [15:0] ADDR_LAST_POS = 16'd18;
	// Byte offset of the protocol field.
	localparam logic [15:0] PROTO_POS = 16'd9;

	// Sums captured at the last byte of a packet.
	typedef struct packed {
		logic [15:0] hdr_sum;
		logic [15:0] seg_sum;
		logic [15:0] pseudo_sum;
		logic [7:0]  proto;
		logic [15:0] seglen;
	} rec_t;

	// Partial results of the final combine.
	typedef struct packed {
		logic [15:0] ip_ck;
		logic [15:0] pair_a;
		logic [15:0] pair_b;
		logic        tcp;
	} part_t;

	// Ones-complement add with end-around carry.
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[15:0] + {15'd0, t[16]};
	endfunction

endpackage

/* hw/rtl/ipv4_tcp_checksum_recompute_top.sv */
// Top level of the IPv4 header and TCP checksum recompute block.
//
// Packet bytes enter one per transaction on the slave stream, first IPv4
// header byte first, with tlast on the final byte. The block accepts one
// byte every cycle while s_axis_tready is high; each completed 16-bit word
// is ones-complement added into the running header or segment sum, address
// words also into the pseudo-header sum. After the last byte, one result
// leaves the output register on the master stream: the header checksum and
// the TCP checksum (zero unless the protocol is TCP), with the TCP flag in
// tuser. The four register stages advance together, so the input is held
// off only while a result sits unaccepted in the output register.
module ipv4_tcp_checksum_recompute_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [15:0] ip_checksum, [31:16] tcp_checksum
	output logic        m_axis_tuser    // [0] is_tcp
);
	import icr_pkg::*;

	logic        adv;
	logic        rec_valid_s2;
	rec_t        rec_s2;
	logic        out_valid_q;
	logic [15:0] ip_ck_q;
	logic [15:0] tcp_ck_q;
	logic        is_tcp_q;

	// The pipeline moves whenever the output register is free or being drained.
	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;

	icr_acc u_acc (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.in_valid     (s_axis_tvalid),
		.in_byte      (s_axis_tdata),
		.in_last      (s_axis_tlast),
		.rec_valid_s2 (rec_valid_s2),
		.rec_s2       (rec_s2)
	);

	icr_fin u_fin (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.rec_valid_s2 (rec_valid_s2),
		.rec_s2       (rec_s2),
		.out_valid_q  (out_valid_q),
		.ip_ck_q      (ip_ck_q),
		.tcp_ck_q     (tcp_ck_q),
		.is_tcp_q     (is_tcp_q)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {tcp_ck_q, ip_ck_q};
	assign m_axis_tuser  = is_tcp_q;

endmodule

/* hw/rtl/icr_acc.sv */
// Input register, header parsing and running ones-complement sums per byte.
module icr_acc (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	output logic              rec_valid_s2,
	output icr_pkg::rec_t     rec_s2
);
	import icr_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	logic [15:0] byte_count_q;
	logic [5:0]  header_bytes_q;
	logic [7:0]  proto_q;
	logic [7:0]  held_q;
	logic [15:0] hdr_sum_q;
	logic [15:0] seg_sum_q;
	logic [15:0] pseudo_sum_q;

	logic [5:0]  hb_eff;
	logic [15:0] hb16;
	logic [7:0]  proto_eff;
	logic        odd;
	logic        paired;
	logic [15:0] word;
	logic [15:0] first;
	logic        in_hdr;
	logic [15:0] hdr_word;
	logic [15:0] seg_word;
	logic [15:0] hdr_next;
	logic [15:0] seg_next;
	logic [15:0] pseudo_next;
	logic [15:0] seglen;
	logic        step;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// Header fields take effect on the byte that carries them.
	assign hb_eff    = (byte_count_q == 16'd0) ? {byte_s1[3:0], 2'b00} : header_bytes_q;
	assign hb16      = {10'd0, hb_eff};
	assign proto_eff = (byte_count_q == PROTO_POS) ? byte_s1 : proto_q;

	// Word forming: odd positions complete a word, a trailing even byte is padded.
	assign odd    = byte_count_q[0];
	assign paired = odd | last_s1;
	assign word   = odd ? {held_q, byte_s1} : {byte_s1, 8'h00};
	assign first  = {byte_count_q[15:1], 1'b0};
	assign in_hdr = first < hb16;

	// Existing checksum fields count as zero.
	assign hdr_word = (first == IP_CKSUM_POS) ? 16'd0 : word;
	assign seg_word = ((first - hb16) == TCP_CKSUM_OFS) ? 16'd0 : word;

	assign hdr_next = (paired && in_hdr) ? oc_add(hdr_sum_q, hdr_word) : hdr_sum_q;
	assign seg_next = (paired && !in_hdr) ? oc_add(seg_sum_q, seg_word) : seg_sum_q;
	assign pseudo_next = (paired && first >= ADDR_FIRST_POS && first <= ADDR_LAST_POS) ?
		oc_add(pseudo_sum_q, word) : pseudo_sum_q;

	assign seglen = byte_count_q + 16'd1 - hb16;
	assign step   = adv && valid_s1;

	// Per-packet state; cleared after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			header_bytes_q <= '0;
			proto_q        <= '0;
			held_q         <= '0;
			hdr_sum_q      <= '0;
			seg_sum_q      <= '0;
			pseudo_sum_q   <= '0;
		end else if (step) begin
			if (last_s1) begin
				byte_count_q   <= '0;
				header_bytes_q <= '0;
				proto_q        <= '0;
				held_q         <= '0;
				hdr_sum_q      <= '0;
				seg_sum_q      <= '0;
				pseudo_sum_q   <= '0;
			end else begin
				byte_count_q   <= byte_count_q + 16'd1;
				header_bytes_q <= hb_eff;
				proto_q        <= proto_eff;
				held_q         <= odd ? held_q : byte_s1;
				hdr_sum_q      <= hdr_next;
				seg_sum_q      <= seg_next;
				pseudo_sum_q   <= pseudo_next;
			end
		end
	end

	// Capture the sums of a finished packet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_s2 <= 1'b0;
		end else if (adv) begin
			rec_valid_s2 <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rec_s2.hdr_sum    <= hdr_next;
			rec_s2.seg_sum    <= seg_next;
			rec_s2.pseudo_sum <= pseudo_next;
			rec_s2.proto      <= proto_eff;
			rec_s2.seglen     <= seglen;
		end
	end

endmodule

/* hw/rtl/icr_fin.sv */
// Final combine of the sums into the two checksums, with the output register.
module icr_fin (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              rec_valid_s2,
	input  icr_pkg::rec_t     rec_s2,
	output logic              out_valid_q,
	output logic [15:0]       ip_ck_q,
	output logic [15:0]       tcp_ck_q,
	output logic              is_tcp_q
);
	import icr_pkg::*;

	logic        valid_s3;
	part_t       part_s3;
	logic [15:0] tcp_sum;

	// Pairwise adds of segment, addresses, protocol and length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= rec_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			part_s3.ip_ck  <= ~rec_s2.hdr_sum;
			part_s3.pair_a <= oc_add(rec_s2.seg_sum, rec_s2.pseudo_sum);
			part_s3.pair_b <= oc_add({8'd0, rec_s2.proto}, rec_s2.seglen);
			part_s3.tcp    <= (rec_s2.proto == PROTO_TCP);
		end
	end

	assign tcp_sum = oc_add(part_s3.pair_a, part_s3.pair_b);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ip_ck_q  <= part_s3.ip_ck;
			tcp_ck_q <= part_s3.tcp ? ~tcp_sum : 16'd0;
			is_tcp_q <= part_s3.tcp;
		end
	end

endmodule

/* hw/rtl/icr_checker.sv */
// Port-level checks of the checksum block and their bind to the top level.
`include "ipv4_tcp_checksum_recompute_top_macros.svh"

module icr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// A stalled result holds its value.
	`ICR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// Input is held off only by a stalled result.
	`ICR_ASSERT_NOW(a_ready_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

	// Non-TCP packets report a zero TCP checksum.
	`ICR_ASSERT_NOW(a_tcp_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[31:16] == 16'd0)

endmodule

bind ipv4_tcp_checksum_recompute_top icr_checker u_icr_checker (.*);
